FILE: sv/skg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Soft-knee gain computer package
// Pipeline depths, fixed-point constants and register map.
// ----------------------------------------------------------------------------
package skg_pkg;

  localparam int LogIters  = 16;
  localparam int QuoBits   = 15;
  localparam int PipeDepth = LogIters + QuoBits + 8;

  localparam logic signed [15:0] DbFloor     = -16'sd25600;
  localparam logic [26:0]        Db20Log2    = 27'd101008905;
  localparam logic signed [15:0] ThreshReset = -16'sd5120;
  localparam logic [10:0]        RatioReset  = 11'd64;
  localparam logic [12:0]        KneeReset   = 13'd1536;

  typedef enum logic [1:0] {
    RegThreshold = 2'd0,
    RegRatio     = 2'd1,
    RegKnee      = 2'd2
  } cfg_reg_t;

endpackage
`default_nettype wire

FILE: sv/soft_knee_gain_computer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Soft-knee compressor gain computer
// Level sample to dB (squaring log2), three-region static curve, rounded
// quotient by a restoring divider, gain change out in signed Q7.8 dB.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  in      | in_valid/in_stall  | level_sample[23:0] signed Q0.23
//  out     | out_valid/out_stall| gain_change_db[15:0] signed Q7.8
//  cfg     | cfg_valid/cfg_ready| cfg_index[1:0], cfg_data[15:0]
//
//  One beat per clock unless the output is stalled; the stages are one leading-one stage, sixteen
//  log2 squaring stages, six curve stages, fifteen divider stages, output.
//  The whole pipeline holds while the output beat is stalled.
//  Synchronous reset clears the valid bits and restores the config registers.
// ----------------------------------------------------------------------------
module soft_knee_gain_computer (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire signed [23:0]  level_sample,
  output logic               out_valid,
  input  wire                out_stall,
  output logic signed [15:0] gain_change_db,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire  [1:0]         cfg_index,
  input  wire  [15:0]        cfg_data
);
  import skg_pkg::*;

  logic signed [15:0] threshold_db;
  logic [10:0]        ratio_x16;
  logic [12:0]        knee_width_db;

  logic [PipeDepth-1:0] vld;
  logic                 adv;

  assign adv       = !(vld[PipeDepth-1] && out_stall);
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;
  assign out_valid = vld[PipeDepth-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_db  <= ThreshReset;
      ratio_x16     <= RatioReset;
      knee_width_db <= KneeReset;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        RegThreshold: threshold_db  <= cfg_data;
        RegRatio:     ratio_x16     <= cfg_data[10:0];
        RegKnee:      knee_width_db <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PipeDepth-2:0], in_valid};
    end
  end

  // derived config
  logic [10:0] r_eff;
  logic [10:0] r_m16;
  logic [23:0] w_r;
  assign r_eff = (ratio_x16 < 11'd16) ? 11'd16 : ratio_x16;
  assign r_m16 = r_eff - 11'd16;
  assign w_r   = knee_width_db * r_eff;

  // leading-one detect and normalize
  logic [30:0] m    [0:LogIters];
  logic [4:0]  pos  [0:LogIters];
  logic        flr  [0:LogIters];
  logic [15:0] frac [0:LogIters];

  logic [4:0] lod;
  always_comb begin
    lod = 5'd0;
    for (int i = 0; i < 23; i++) begin
      if (level_sample[i]) lod = 5'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m[0]    <= 31'({level_sample[22:0], 8'b0} << (5'd22 - lod));
      pos[0]  <= lod;
      flr[0]  <= (level_sample == 24'sd0) || level_sample[23];
      frac[0] <= '0;
    end
  end

  // log2 fraction, one bit per stage
  for (genvar g = 0; g < LogIters; g++) begin : g_log
    logic [61:0] prod;
    logic [31:0] sq;
    assign prod = {31'b0, m[g]} * {31'b0, m[g]};
    assign sq   = prod[61:30];
    always_ff @(posedge clk) begin
      if (adv) begin
        m[g+1]    <= sq[31] ? sq[31:1] : sq[30:0];
        frac[g+1] <= {frac[g][14:0], sq[31]};
        pos[g+1]  <= pos[g];
        flr[g+1]  <= flr[g];
      end
    end
  end

  // scale to dB
  logic [20:0] abs_l;
  logic [47:0] mag;
  logic        mag_flr;
  assign abs_l = {5'd23 - pos[LogIters], 16'b0} - {5'b0, frac[LogIters]};

  always_ff @(posedge clk) begin
    if (adv) begin
      mag     <= abs_l * Db20Log2;
      mag_flr <= flr[LogIters];
    end
  end

  logic [47:0]        mag_rnd;
  logic [15:0]        q_db;
  logic signed [15:0] lvl;
  assign mag_rnd = mag + 48'h0000_8000_0000;
  assign q_db    = mag_rnd[47:32];

  always_ff @(posedge clk) begin
    if (adv) begin
      lvl <= (mag_flr || q_db > 16'd25600) ? DbFloor : -$signed(q_db);
    end
  end

  // region select
  logic signed [17:0] o;
  logic signed [18:0] o2;
  logic signed [18:0] wx;
  logic [16:0]        a_next;
  logic               knee_next;
  logic [16:0]        a;
  logic               knee;

  assign o  = {{2{lvl[15]}}, lvl} - {{2{threshold_db[15]}}, threshold_db};
  assign o2 = {o, 1'b0};
  assign wx = {6'b0, knee_width_db};

  always_comb begin
    a_next    = '0;
    knee_next = 1'b0;
    if (knee_width_db == 13'd0) begin
      if (o > 18'sd0) a_next = o[16:0];
    end else if (o2 < -wx) begin
      a_next = '0;
    end else if (o2 <= wx) begin
      knee_next = 1'b1;
      a_next    = 17'(o2 + wx);
    end else begin
      a_next = o[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a    <= a_next;
      knee <= knee_next;
    end
  end

  // numerator and denominator
  logic [27:0] sqv;
  logic [26:0] den_b;
  always_ff @(posedge clk) begin
    if (adv) begin
      sqv   <= knee ? 28'(a * a) : {11'b0, a};
      den_b <= knee ? {w_r, 3'b0} : {16'b0, r_eff};
    end
  end

  logic [38:0] num;
  logic [26:0] den_c;
  always_ff @(posedge clk) begin
    if (adv) begin
      num   <= sqv * r_m16;
      den_c <= den_b;
    end
  end

  logic [39:0] rem [0:QuoBits];
  logic [26:0] den [0:QuoBits];
  logic        ovf [0:QuoBits];
  logic [14:0] quo [0:QuoBits];

  logic [39:0] n_rnd;
  assign n_rnd = {1'b0, num} + {14'b0, den_c[26:1]};

  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0] <= n_rnd;
      den[0] <= den_c;
      ovf[0] <= {2'b0, n_rnd} >= {den_c, 15'b0};
      quo[0] <= '0;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar g = 0; g < QuoBits; g++) begin : g_div
    localparam int K = QuoBits - 1 - g;
    logic [41:0] dk;
    logic        ge;
    assign dk = {15'b0, den[g]} << K;
    assign ge = {2'b0, rem[g]} >= dk;
    always_ff @(posedge clk) begin
      if (adv) begin
        rem[g+1] <= ge ? 40'({2'b0, rem[g]} - dk) : rem[g];
        quo[g+1] <= {quo[g][13:0], ge};
        den[g+1] <= den[g];
        ovf[g+1] <= ovf[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      gain_change_db <= ovf[QuoBits] ? 16'sh8000 : -$signed({1'b0, quo[QuoBits]});
    end
  end

endmodule
`default_nettype wire
